FILE: src/lfrd_pkg.sv
// ----------------------------------------------------------------------------
// lfrd_pkg
// Shared types and constants of the length framed reply deframer.
// ----------------------------------------------------------------------------
package lfrd_pkg;

  localparam int LEN_WIDTH  = 12;
  localparam int CFG_WIDTH  = 12;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE  = 2'd0,
    CFG_END_BYTE   = 2'd1,
    CFG_MAX_LENGTH = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_CMD    = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_BODY   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD_CMD = 3'd2,
    ST_BAD_LEN = 3'd3,
    ST_BAD_END = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    KIND_NONE       = 3'd0,
    KIND_STATUS     = 3'd1,
    KIND_DTV_STATE  = 3'd2,
    KIND_AUTOSEARCH = 3'd3,
    KIND_HEARTBEAT  = 3'd4,
    KIND_CONSTEL    = 3'd5,
    KIND_MULTIPATH  = 3'd6
  } kind_t;

  localparam logic [7:0] CMD_STATUS     = 8'h11;
  localparam logic [7:0] CMD_AUTOSEARCH = 8'hF3;
  localparam logic [7:0] CMD_HEART      = 8'hF4;
  localparam logic [7:0] CMD_TUNE       = 8'hF6;
  localparam logic [7:0] CMD_CHANNEL    = 8'h22;
  localparam logic [7:0] CMD_CONSTEL    = 8'hF9;
  localparam logic [7:0] CMD_MULTIPATH  = 8'hF1;

  localparam logic [LEN_WIDTH-1:0] LEN_STATUS     = 12'd42;
  localparam logic [LEN_WIDTH-1:0] LEN_SHORT      = 12'd8;
  localparam logic [LEN_WIDTH-1:0] LEN_AUTOSEARCH = 12'd12;
  localparam logic [LEN_WIDTH-1:0] LEN_HEART      = 12'd4;
  localparam logic [LEN_WIDTH-1:0] LEN_CONSTEL    = 12'd2054;
  localparam logic [LEN_WIDTH-1:0] LEN_MIN        = 12'd4;

  localparam logic [7:0]           RST_SYNC_BYTE  = 8'hAA;
  localparam logic [7:0]           RST_END_BYTE   = 8'h55;
  localparam logic [LEN_WIDTH-1:0] RST_MAX_LENGTH = 12'd2054;

  function automatic logic known_command(input logic [7:0] c);
    known_command = (c == CMD_STATUS) || (c == CMD_AUTOSEARCH) || (c == CMD_HEART) ||
                    (c == CMD_TUNE) || (c == CMD_CHANNEL) || (c == CMD_CONSTEL) ||
                    (c == CMD_MULTIPATH);
  endfunction

  function automatic kind_t classify(input logic [7:0] c, input logic [LEN_WIDTH-1:0] len);
    if (c == CMD_STATUS && len == LEN_STATUS) begin
      classify = KIND_STATUS;
    end else if (c == CMD_STATUS && len == LEN_SHORT) begin
      classify = KIND_DTV_STATE;
    end else if (c == CMD_AUTOSEARCH && len == LEN_AUTOSEARCH) begin
      classify = KIND_AUTOSEARCH;
    end else if (c == CMD_HEART && len == LEN_HEART) begin
      classify = KIND_HEARTBEAT;
    end else if (c == CMD_CONSTEL && len == LEN_CONSTEL) begin
      classify = KIND_CONSTEL;
    end else if (c == CMD_MULTIPATH && len == LEN_SHORT) begin
      classify = KIND_MULTIPATH;
    end else begin
      classify = KIND_NONE;
    end
  endfunction

endpackage

FILE: src/lfrd_if.sv
// ----------------------------------------------------------------------------
// lfrd_if
// Valid/ready channels of the deframer: received bytes in, frame words out.
// ----------------------------------------------------------------------------
interface lfrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfrd_tx_if #(
  parameter int POSITION_WIDTH = 12
);
  logic                      valid;
  logic                      ready;
  logic [7:0]                frame_byte;
  logic [POSITION_WIDTH-1:0] byte_position;
  logic                      last_of_frame;
  lfrd_pkg::status_t         frame_status;
  lfrd_pkg::kind_t           frame_kind;

  modport source (output valid, output frame_byte, output byte_position,
                  output last_of_frame, output frame_status, output frame_kind,
                  input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last_of_frame, input frame_status, input frame_kind,
                  output ready);
endinterface

FILE: src/length_framed_reply_deframer_unit.sv
// ----------------------------------------------------------------------------
// length_framed_reply_deframer_unit
// Sync/length framed reply deframer, one received byte per cycle while tx is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries received link bytes. While hunting, bytes other than the sync
//   byte are consumed without a result. From the sync byte on, every byte of
//   a candidate frame leaves on tx as one word with its position, a last flag,
//   a status (in progress, good, bad command, bad length, bad end) and, on a
//   good last byte, the frame kind.
//   Each accepted byte's result is registered and shows on tx in the cycle after.
//   Throughput is one byte per cycle while tx is not stalled; the per-byte parse
//   logic and the single output register set that figure.
//   When tx stalls, the output register holds its word and rx.ready stays
//   high only if that word is taken in the same cycle.
//   Reset returns the parser to hunting, empties the output register and
//   loads sync 0xAA, end 0x55 and max length 2054.
//   Configuration (cfg_we/cfg_index/cfg_data) must be written while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module length_framed_reply_deframer_unit #(
  parameter int POSITION_WIDTH = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lfrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lfrd_pkg::CFG_WIDTH-1:0]     cfg_data,
  lfrd_rx_if.sink                            rx,
  lfrd_tx_if.source                          tx
);

  localparam int LW = lfrd_pkg::LEN_WIDTH;
  // Common width for comparing positions against frame lengths.
  localparam int CW = ((POSITION_WIDTH > LW) ? POSITION_WIDTH : LW) + 1;
  localparam int unsigned POS_MAX = (1 << POSITION_WIDTH) - 1;

  // Configuration registers
  logic [7:0]    sync_byte;
  logic [7:0]    end_byte;
  logic [LW-1:0] max_length;

  // Parser state
  lfrd_pkg::phase_t          parse_phase, parse_phase_next;
  logic [7:0]                command_code, command_code_next;
  logic [LW-1:0]             frame_length, frame_length_next;
  logic [POSITION_WIDTH-1:0] bytes_seen, bytes_seen_next;

  // Result of the byte on rx this cycle
  logic                      res_valid;
  logic [POSITION_WIDTH-1:0] res_pos;
  logic                      res_last;
  lfrd_pkg::status_t         res_status;
  lfrd_pkg::kind_t           res_kind;

  logic accept;
  logic [15:0] len_wide;
  logic        len_lo_ok, len_hi_ok;
  logic [CW-1:0] next_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte  <= lfrd_pkg::RST_SYNC_BYTE;
      end_byte   <= lfrd_pkg::RST_END_BYTE;
      max_length <= lfrd_pkg::RST_MAX_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        lfrd_pkg::CFG_SYNC_BYTE:  sync_byte  <= cfg_data[7:0];
        lfrd_pkg::CFG_END_BYTE:   end_byte   <= cfg_data[7:0];
        lfrd_pkg::CFG_MAX_LENGTH: max_length <= cfg_data[LW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Take a new byte whenever the output register is free or being drained.
  assign rx.ready = !tx.valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  // Length checks: one-byte form and two-byte (low byte first) form.
  assign len_wide  = {rx.rx_byte, frame_length[7:0]};
  assign len_lo_ok = ({4'd0, rx.rx_byte} >= lfrd_pkg::LEN_MIN) &&
                     ({4'd0, rx.rx_byte} <= max_length) &&
                     ({8'd0, rx.rx_byte} <= 16'(POS_MAX));
  assign len_hi_ok = (len_wide >= {4'd0, lfrd_pkg::LEN_MIN}) &&
                     (len_wide <= {4'd0, max_length}) &&
                     (len_wide <= 16'(POS_MAX));
  assign next_pos  = CW'(bytes_seen) + CW'(1);

  always_comb begin
    parse_phase_next  = parse_phase;
    command_code_next = command_code;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    res_valid         = 1'b1;
    res_pos           = '0;
    res_last          = 1'b0;
    res_status        = lfrd_pkg::ST_BUSY;
    res_kind          = lfrd_pkg::KIND_NONE;

    case (parse_phase)
      lfrd_pkg::PH_CMD: begin
        res_pos = POSITION_WIDTH'(1);
        if (!lfrd_pkg::known_command(rx.rx_byte)) begin
          res_last         = 1'b1;
          res_status       = lfrd_pkg::ST_BAD_CMD;
          parse_phase_next = lfrd_pkg::PH_HUNT;
        end else begin
          command_code_next = rx.rx_byte;
          parse_phase_next  = lfrd_pkg::PH_LEN_LO;
        end
      end
      lfrd_pkg::PH_LEN_LO: begin
        res_pos = POSITION_WIDTH'(2);
        if (command_code == lfrd_pkg::CMD_CONSTEL) begin
          // Constellation frames carry a two-byte length; hold the low byte.
          frame_length_next = {4'd0, rx.rx_byte};
          parse_phase_next  = lfrd_pkg::PH_LEN_HI;
        end else if (!len_lo_ok) begin
          res_last         = 1'b1;
          res_status       = lfrd_pkg::ST_BAD_LEN;
          parse_phase_next = lfrd_pkg::PH_HUNT;
        end else begin
          frame_length_next = {4'd0, rx.rx_byte};
          bytes_seen_next   = POSITION_WIDTH'(3);
          parse_phase_next  = lfrd_pkg::PH_BODY;
        end
      end
      lfrd_pkg::PH_LEN_HI: begin
        res_pos = POSITION_WIDTH'(3);
        if (!len_hi_ok) begin
          res_last         = 1'b1;
          res_status       = lfrd_pkg::ST_BAD_LEN;
          parse_phase_next = lfrd_pkg::PH_HUNT;
        end else if (len_wide[LW-1:0] == lfrd_pkg::LEN_MIN) begin
          // Shortest constellation frame: the high length byte is the end byte.
          frame_length_next = len_wide[LW-1:0];
          res_last          = 1'b1;
          parse_phase_next  = lfrd_pkg::PH_HUNT;
          if (rx.rx_byte == end_byte) begin
            res_status = lfrd_pkg::ST_GOOD;
            res_kind   = lfrd_pkg::classify(command_code, len_wide[LW-1:0]);
          end else begin
            res_status = lfrd_pkg::ST_BAD_END;
          end
        end else begin
          frame_length_next = len_wide[LW-1:0];
          bytes_seen_next   = POSITION_WIDTH'(4);
          parse_phase_next  = lfrd_pkg::PH_BODY;
        end
      end
      lfrd_pkg::PH_BODY: begin
        res_pos = bytes_seen;
        if (next_pos >= CW'(frame_length)) begin
          res_last         = 1'b1;
          parse_phase_next = lfrd_pkg::PH_HUNT;
          if (rx.rx_byte == end_byte) begin
            res_status = lfrd_pkg::ST_GOOD;
            res_kind   = lfrd_pkg::classify(command_code, frame_length);
          end else begin
            res_status = lfrd_pkg::ST_BAD_END;
          end
        end else begin
          bytes_seen_next = next_pos[POSITION_WIDTH-1:0];
        end
      end
      default: begin
        // Hunting, and any unused phase code.
        parse_phase_next = lfrd_pkg::PH_HUNT;
        if (rx.rx_byte != sync_byte) begin
          res_valid = 1'b0;
        end else begin
          command_code_next = '0;
          frame_length_next = '0;
          bytes_seen_next   = '0;
          parse_phase_next  = lfrd_pkg::PH_CMD;
        end
      end
    endcase
  end

  // Advance the parser on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= lfrd_pkg::PH_HUNT;
      command_code <= '0;
      frame_length <= '0;
      bytes_seen   <= '0;
    end else if (accept) begin
      parse_phase  <= parse_phase_next;
      command_code <= command_code_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
    end
  end

  // Output register: load on accept, drop the valid once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (accept) begin
      tx.valid <= res_valid;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx.frame_byte    <= rx.rx_byte;
      tx.byte_position <= res_pos;
      tx.last_of_frame <= res_last;
      tx.frame_status  <= res_status;
      tx.frame_kind    <= res_kind;
    end
  end

endmodule
